// ===== rtl/sorted_set_table_assert.svh =====
// Assertion macros for the sorted set table.
`ifndef SORTED_SET_TABLE_ASSERT_SVH
`define SORTED_SET_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sst_pkg.sv =====
// Shared types, widths and codes of the sorted set table.
package sst_pkg;

  localparam int DATA_W      = 32;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int CAPACITY_DEF = 64;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MEMBER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // Shift command broadcast to every cell.
  typedef struct packed {
    logic ins;   // open a slot at the insert position, shift up
    logic del;   // close the slot at the delete position, shift down
  } upd_t;

endpackage

// ===== rtl/sst_cell.sv =====
// One compare-and-shift cell of the sorted set table.
module sst_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 7
) (
  input  logic                              clk,
  input  logic                              cmp_en,
  input  logic signed [sst_pkg::DATA_W-1:0] cmp_key,
  input  logic signed [sst_pkg::DATA_W-1:0] ins_key,
  input  logic [CW-1:0]                     count,
  input  sst_pkg::upd_t                     upd,
  input  logic                              left_lt,
  input  logic signed [sst_pkg::DATA_W-1:0] left_val,
  input  logic signed [sst_pkg::DATA_W-1:0] right_val,
  output logic signed [sst_pkg::DATA_W-1:0] val,
  output logic                              lt,
  output logic                              eq
);

  logic signed [sst_pkg::DATA_W-1:0] val_r;
  logic                              lt_r;
  logic                              eq_r;
  logic                              live;

  // Only entries below the count take part in the compare.
  assign live = (CW'(INDEX) < count);

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lt_r <= live && (val_r < cmp_key);
      eq_r <= live && (val_r == cmp_key);
    end
    if (upd.ins && !lt_r) begin
      val_r <= left_lt ? ins_key : left_val;
    end else if (upd.del && !lt_r) begin
      val_r <= right_val;
    end
  end

  assign val = val_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

endmodule

// ===== rtl/sorted_set_table.sv =====
// Top level of the sorted set table: a row of compare-and-shift cells.
//
//  channel | ports                          | transfer carries
//  --------+--------------------------------+-------------------------------
//  input   | in_tvalid/in_tready/in_t*      | kind (tuser), key_value (tdata)
//  output  | out_tvalid/out_tready/out_tdata| status, entry_count
//
// A request has an accept step, which registers each cell's less-than and equal
// flags, and an apply step, which reduces them to hit and position and shifts all
// cells at once; a new request is taken only after the last one has been applied.
// Synchronous reset (rst_n low) clears the state, the entry count and the
// output valid; entries at or above the count are never read, so no clearing.
// A request is taken while a result waits; its apply step holds until it drains.
module sorted_set_table #(
  parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key_value
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [8:2] entry_count, rest zero
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic                                state_r, state_nxt;
  logic [CW-1:0]                       count_r, count_nxt;
  logic [sst_pkg::KIND_W-1:0]          kind_r;
  logic signed [sst_pkg::DATA_W-1:0]   key_r;
  logic                                out_valid_r, out_valid_nxt;
  logic [sst_pkg::STATUS_W-1:0]        status_r, status_nxt;
  logic [sst_pkg::COUNT_OUT_W-1:0]     ocount_r;

  logic                                in_go;
  logic                                apply_go;
  logic                                hit;
  logic                                full;
  sst_pkg::upd_t                       upd;

  logic signed [sst_pkg::DATA_W-1:0]   cell_val [CAPACITY];
  logic [CAPACITY-1:0]                 cell_lt;
  logic [CAPACITY-1:0]                 cell_eq;

  assign in_tready = (state_r == S_IDLE);
  assign in_go     = in_tvalid && in_tready;
  // Hold the apply step while an earlier result still waits downstream.
  assign apply_go  = (state_r == S_APPLY) && (!out_valid_r || out_tready);

  assign hit  = |cell_eq;
  assign full = (count_r >= CW'(CAPACITY));

  // Cell row: each cell sees its lower neighbor for insert, upper for delete.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              nb_lt;
    logic signed [sst_pkg::DATA_W-1:0] nb_lo;
    logic signed [sst_pkg::DATA_W-1:0] nb_hi;

    if (i == 0) begin : g_first
      assign nb_lt = 1'b1;
      assign nb_lo = key_r;
    end else begin : g_mid
      assign nb_lt = cell_lt[i-1];
      assign nb_lo = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign nb_hi = key_r;
    end else begin : g_up
      assign nb_hi = cell_val[i+1];
    end

    sst_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .cmp_en    (in_go),
      .cmp_key   (in_tdata),
      .ins_key   (key_r),
      .count     (count_r),
      .upd       (upd),
      .left_lt   (nb_lt),
      .left_val  (nb_lo),
      .right_val (nb_hi),
      .val       (cell_val[i]),
      .lt        (cell_lt[i]),
      .eq        (cell_eq[i])
    );
  end

  // Decide the operation from the registered flags.
  always_comb begin
    upd        = '0;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (apply_go) begin
      status_nxt = sst_pkg::ST_DONE;
      case (kind_r)
        sst_pkg::KIND_INSERT: begin
          if (hit) begin
            status_nxt = sst_pkg::ST_PRESENT;
          end else if (full) begin
            status_nxt = sst_pkg::ST_FULL;
          end else begin
            upd.ins   = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        sst_pkg::KIND_MEMBER: begin
          if (!hit) begin
            status_nxt = sst_pkg::ST_ABSENT;
          end
        end
        sst_pkg::KIND_DELETE: begin
          if (hit) begin
            upd.del   = 1'b1;
            count_nxt = count_r - CW'(1);
          end else begin
            status_nxt = sst_pkg::ST_ABSENT;
          end
        end
        default: begin
          count_nxt = '0;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_go) state_nxt = S_APPLY;
      S_APPLY: if (apply_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (apply_go)   out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: capture the request, load the result on apply.
  always_ff @(posedge clk) begin
    if (in_go) begin
      kind_r <= in_tuser;
      key_r  <= in_tdata;
    end
    status_r <= status_nxt;
    if (apply_go) begin
      ocount_r <= sst_pkg::COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, ocount_r, status_r};

`include "sorted_set_table_assert.svh"

  `SST_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(CAPACITY),
                   "entry count above capacity")
  `SST_ASSERT_NEXT(a_ins_count, apply_go && upd.ins,
                   count_r == $past(count_r) + CW'(1), "insert did not grow count")
  `SST_ASSERT_NEXT(a_apply_out, apply_go, out_tvalid, "apply step left no result")
  `SST_ASSERT_IMPL(a_full_flag, out_tvalid && status_r == sst_pkg::ST_FULL,
                   count_r == CW'(CAPACITY), "full status with free entries")

endmodule
